// ===== hdl/sbd_pkg.sv =====
// ============================================================================
// sbd_pkg: shared types and constants of the stereo bitcrusher
// Payload structs, configuration layout, dither mode codes, lane control
// and the controller states used by every file of the block.
// ============================================================================
package sbd_pkg;

    // Field widths of the audio and random words.
    localparam int SAMPLE_W = 24;
    localparam int RAND_W   = 16;
    localparam int ERR_W    = SAMPLE_W + 2;

    // Configuration register widths.
    localparam int PHASE_W = 33;
    localparam int QSTEP_W = 22;
    localparam int RECIP_W = 32;
    localparam int MODE_W  = 3;

    // Configuration port layout: one 64-bit register every 8 bytes.
    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 5;
    localparam int REG_IDX_W  = 2;

    // Register indexes.
    localparam logic [REG_IDX_W-1:0] REG_PHASE_STEP = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_QUANT_STEP = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_QUANT_RECIP = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_DITHER_MODE = 2'd3;

    // Reset values of the registers.
    localparam logic [PHASE_W-1:0] PHASE_STEP_RST = 33'h1_0000_0000;
    localparam logic [QSTEP_W-1:0] QUANT_STEP_RST = 22'd20480;
    localparam logic [RECIP_W-1:0] QUANT_RECIP_RST = 32'd209715;
    localparam logic [MODE_W-1:0]  DITHER_MODE_RST = 3'd3;

    // Dither mode codes; the two unused codes behave as no dither.
    localparam logic [MODE_W-1:0] DM_NONE    = 3'd0;
    localparam logic [MODE_W-1:0] DM_RECT    = 3'd1;
    localparam logic [MODE_W-1:0] DM_TRI     = 3'd2;
    localparam logic [MODE_W-1:0] DM_TRI_ALT = 3'd3;
    localparam logic [MODE_W-1:0] DM_TRI_FO  = 3'd4;
    localparam logic [MODE_W-1:0] DM_TRI_SO  = 3'd5;

    // One input transfer.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_left;
        logic signed [SAMPLE_W-1:0] sample_right;
        logic [RAND_W-1:0]          rand_left_a;
        logic [RAND_W-1:0]          rand_left_b;
        logic [RAND_W-1:0]          rand_right_a;
        logic [RAND_W-1:0]          rand_right_b;
    } t_in_item;

    // One output transfer.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] held_left;
        logic signed [SAMPLE_W-1:0] held_right;
        logic                       updated;
    } t_out_item;

    // Live configuration.
    typedef struct packed {
        logic [PHASE_W-1:0] phase_step;
        logic [QSTEP_W-1:0] quant_step;
        logic [RECIP_W-1:0] quant_step_recip;
        logic [MODE_W-1:0]  dither_mode;
    } t_cfg;

    // Stage strobes from the controller to both lanes.
    typedef struct packed {
        logic en_dither;
        logic en_mag;
        logic en_mult;
        logic en_round;
        logic en_scale;
        logic en_commit;
    } t_lane_ctrl;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DITHER,
        ST_MAG,
        ST_MULT,
        ST_ROUND,
        ST_SCALE,
        ST_COMMIT,
        ST_DONE
    } t_state;

    // Bring a random word to 16 fraction bits: cut or pad with zeros.
    function automatic logic [15:0] rand_q16(input logic [RAND_W-1:0] r);
        logic [RAND_W+15:0] t;
        t = {r, 16'h0000};
        return 16'(t >> RAND_W);
    endfunction

endpackage

// ===== hdl/sbd_regs.sv =====
// ============================================================================
// sbd_regs: configuration registers
// APB-style slave holding the hold rate, quantization step, its reciprocal
// and the dither mode. Writes complete in the access cycle; reads return
// the stored value.
// ============================================================================
module sbd_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sbd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [sbd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [sbd_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output sbd_pkg::t_cfg                  o_cfg
);
    import sbd_pkg::*;

    t_cfg                 r_cfg;
    logic                 w_wr;
    logic [REG_IDX_W-1:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = paddr[APB_ADDR_W-1:APB_ADDR_W-REG_IDX_W];
    assign o_cfg  = r_cfg;

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_step       <= PHASE_STEP_RST;
            r_cfg.quant_step       <= QUANT_STEP_RST;
            r_cfg.quant_step_recip <= QUANT_RECIP_RST;
            r_cfg.dither_mode      <= DITHER_MODE_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_PHASE_STEP:  r_cfg.phase_step       <= pwdata[PHASE_W-1:0];
                REG_QUANT_STEP:  r_cfg.quant_step       <= pwdata[QSTEP_W-1:0];
                REG_QUANT_RECIP: r_cfg.quant_step_recip <= pwdata[RECIP_W-1:0];
                REG_DITHER_MODE: r_cfg.dither_mode      <= pwdata[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    // Read-back multiplexer.
    always_comb begin
        case (w_idx)
            REG_PHASE_STEP:  prdata = APB_DATA_W'(r_cfg.phase_step);
            REG_QUANT_STEP:  prdata = APB_DATA_W'(r_cfg.quant_step);
            REG_QUANT_RECIP: prdata = APB_DATA_W'(r_cfg.quant_step_recip);
            REG_DITHER_MODE: prdata = APB_DATA_W'(r_cfg.dither_mode);
            default:         prdata = '0;
        endcase
    end

endmodule

// ===== hdl/sbd_lane.sv =====
// ============================================================================
// sbd_lane: one channel of the requantizer
// Adds dither and error feedback, rounds to the nearest multiple of the
// quantization step through the reciprocal, and keeps the held sample and
// the last two quantization errors of its channel.
// ============================================================================
module sbd_lane (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sbd_pkg::t_lane_ctrl                 i_ctrl,
    input  sbd_pkg::t_cfg                       i_cfg,
    input  logic signed [sbd_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [sbd_pkg::RAND_W-1:0]          i_rand_a,
    input  logic [sbd_pkg::RAND_W-1:0]          i_rand_b,
    output logic signed [sbd_pkg::SAMPLE_W-1:0] o_held
);
    import sbd_pkg::*;

    // Working widths; all but DIFF_W are derived from the field widths.
    localparam int DIFF_W = 17;
    localparam int DITH_W = DIFF_W + QSTEP_W + 1;
    localparam int FB_W   = ERR_W + 17;
    localparam int XD_W   = ((FB_W > DITH_W) ? FB_W : DITH_W) + 2;
    localparam int MAG_W  = XD_W;
    localparam int PLO_W  = 2 * RECIP_W;
    localparam int SUM_W  = MAG_W + 1;
    localparam int N_W    = MAG_W - 15;
    localparam int YM_W   = N_W + QSTEP_W;
    localparam int Y_W    = YM_W + 1;
    localparam int E_W    = Y_W + 1;
    localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(32768);
    localparam logic signed [DIFF_W-1:0] RECT_MID = 17'sd32768;

    // Pipeline registers.
    logic signed [DITH_W-1:0]   r_dith;
    logic signed [FB_W-1:0]     r_fb;
    logic [MAG_W-1:0]           r_mag;
    logic                       r_neg;
    logic [PLO_W-1:0]           r_plo;
    logic [MAG_W-1:0]           r_phi;
    logic [N_W-1:0]             r_n;
    logic [YM_W-1:0]            r_ymag;

    // Channel state.
    logic signed [ERR_W-1:0]    r_err0;
    logic signed [ERR_W-1:0]    r_err1;
    logic signed [SAMPLE_W-1:0] r_held;

    logic [15:0]                w_a16;
    logic [15:0]                w_b16;
    logic signed [DIFF_W-1:0]   w_diff;
    logic signed [DITH_W-1:0]   w_dith;
    logic signed [FB_W-1:0]     w_fb;
    logic signed [XD_W-1:0]     w_xd;
    logic [SUM_W-1:0]           w_sum;
    logic signed [Y_W-1:0]      w_y;
    logic signed [E_W-1:0]      w_e;

    // Clamp a wide signed value to the error width.
    function automatic logic [ERR_W-1:0] sat_err(input logic [E_W-1:0] v);
        logic [E_W-ERR_W:0] top;
        top = v[E_W-1:ERR_W-1];
        if ((&top) || !(|top)) begin
            return v[ERR_W-1:0];
        end
        return v[E_W-1] ? {1'b1, {(ERR_W-1){1'b0}}} : {1'b0, {(ERR_W-1){1'b1}}};
    endfunction

    // Clamp a wide signed value to the sample width.
    function automatic logic [SAMPLE_W-1:0] sat_sample(input logic [Y_W-1:0] v);
        logic [Y_W-SAMPLE_W:0] top;
        top = v[Y_W-1:SAMPLE_W-1];
        if ((&top) || !(|top)) begin
            return v[SAMPLE_W-1:0];
        end
        return v[Y_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    endfunction

    assign o_held = r_held;
    assign w_a16  = rand_q16(i_rand_a);
    assign w_b16  = rand_q16(i_rand_b);

    // Dither amplitude and error feedback, chosen by mode.
    always_comb begin
        w_diff = '0;
        w_fb   = '0;
        case (i_cfg.dither_mode)
            DM_RECT: begin
                w_diff = $signed({1'b0, w_a16}) - RECT_MID;
            end
            DM_TRI, DM_TRI_ALT: begin
                w_diff = $signed({1'b0, w_a16}) - $signed({1'b0, w_b16});
            end
            DM_TRI_FO: begin
                w_diff = $signed({1'b0, w_a16}) - $signed({1'b0, w_b16});
                w_fb   = FB_W'(r_err0) <<< 15;
            end
            DM_TRI_SO: begin
                w_diff = $signed({1'b0, w_a16}) - $signed({1'b0, w_b16});
                w_fb   = (FB_W'(r_err0) <<< 16) - (FB_W'(r_err1) <<< 15);
            end
            default: ;
        endcase
        w_dith = DITH_W'(w_diff) * DITH_W'($signed({1'b0, i_cfg.quant_step}));
    end

    // Dithered value with 16 fraction bits.
    assign w_xd = (XD_W'(i_sample) <<< 16) + XD_W'(r_dith) + XD_W'(r_fb);

    // Scaled quotient plus one half, then the integer part.
    assign w_sum = SUM_W'(r_phi) + SUM_W'(r_plo[PLO_W-1:32]) + ROUND_HALF;

    // Signed quantized value and its error against the input.
    assign w_y = r_neg ? -$signed({1'b0, r_ymag}) : $signed({1'b0, r_ymag});
    assign w_e = E_W'(w_y) - E_W'(i_sample);

    // Datapath stages, one per controller state.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.en_dither) begin
            r_dith <= w_dith;
            r_fb   <= w_fb;
        end
        if (i_ctrl.en_mag) begin
            r_neg <= w_xd[XD_W-1];
            r_mag <= w_xd[XD_W-1] ? MAG_W'(-w_xd) : MAG_W'(w_xd);
        end
        if (i_ctrl.en_mult) begin
            r_plo <= PLO_W'(r_mag[31:0]) * PLO_W'(i_cfg.quant_step_recip);
            r_phi <= MAG_W'(r_mag[MAG_W-1:32]) * MAG_W'(i_cfg.quant_step_recip);
        end
        if (i_ctrl.en_round) begin
            r_n <= w_sum[SUM_W-1:16];
        end
        if (i_ctrl.en_scale) begin
            r_ymag <= YM_W'(r_n) * YM_W'(i_cfg.quant_step);
        end
    end

    // Held sample and error history.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err0 <= '0;
            r_err1 <= '0;
            r_held <= '0;
        end else if (i_ctrl.en_commit) begin
            r_err1 <= r_err0;
            r_err0 <= sat_err(w_e);
            r_held <= sat_sample(w_y);
        end
    end

endmodule

// ===== hdl/stereo_bitcrusher_dither.sv =====
// ============================================================================
// stereo_bitcrusher_dither: stereo sample-and-hold bitcrusher with dither
// Two requantizer lanes work on left and right side by side, sequenced by
// one controller that also runs the hold-rate phase accumulator.
// ============================================================================
// Usage:
// - Input channel (i_in_valid, o_in_stall, i_in_data): one stereo pair and
//   four uniform random words per transfer, one transfer per audio tick.
// - Output channel (o_out_valid, i_out_stall, o_out_data): exactly one
//   transfer per input, with the held left/right samples and a flag that is
//   set when this tick took a new sample.
// - A tick that resamples runs six datapath steps in both lanes at once,
//   one per controller state, before ST_DONE loads the output register;
//   the next input is taken only after that load. A tick that holds
//   skips the datapath and goes straight to ST_DONE.
// - o_in_stall is high while a pair is in work. A result waits in the
//   output register while i_out_stall is high, and the controller holds
//   a finished pair until that register is free.
// - Reset clears the phase, the held samples and the error history and
//   loads the register defaults (resample every tick, triangular dither).
// - Configuration is to be written through the APB port only while no
//   pair is in work; the block itself does not enforce this.
// ============================================================================
module stereo_bitcrusher_dither (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  sbd_pkg::t_in_item              i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output sbd_pkg::t_out_item             o_out_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sbd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [sbd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [sbd_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import sbd_pkg::*;

    t_state                     r_state;
    t_state                     n_state;
    t_in_item                   r_in;
    logic [31:0]                r_phase;
    logic                       r_upd;
    logic                       r_out_valid;
    t_out_item                  r_out_data;
    t_cfg                       w_cfg;
    t_lane_ctrl                 w_ctrl;
    logic                       w_in_xfer;
    logic                       w_out_load;
    logic [32:0]                w_phase_sum;
    logic                       w_take;
    logic signed [SAMPLE_W-1:0] w_held_l;
    logic signed [SAMPLE_W-1:0] w_held_r;

    // Configuration registers.
    sbd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Left and right lanes.
    sbd_lane u_lane_left (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_ctrl),
        .i_cfg    (w_cfg),
        .i_sample (r_in.sample_left),
        .i_rand_a (r_in.rand_left_a),
        .i_rand_b (r_in.rand_left_b),
        .o_held   (w_held_l)
    );

    sbd_lane u_lane_right (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_ctrl),
        .i_cfg    (w_cfg),
        .i_sample (r_in.sample_right),
        .i_rand_a (r_in.rand_right_a),
        .i_rand_b (r_in.rand_right_b),
        .o_held   (w_held_r)
    );

    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_in_xfer   = i_in_valid & ~o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Phase accumulator: a carry out of bit 31, or a full step, resamples.
    assign w_phase_sum = {1'b0, r_phase} + {1'b0, w_cfg.phase_step[31:0]};
    assign w_take      = w_cfg.phase_step[PHASE_W-1] | w_phase_sum[32];

    // Next state and lane strobes.
    always_comb begin
        n_state    = r_state;
        w_ctrl     = '0;
        w_out_load = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    n_state = w_take ? ST_DITHER : ST_DONE;
                end
            end
            ST_DITHER: begin
                w_ctrl.en_dither = 1'b1;
                n_state          = ST_MAG;
            end
            ST_MAG: begin
                w_ctrl.en_mag = 1'b1;
                n_state       = ST_MULT;
            end
            ST_MULT: begin
                w_ctrl.en_mult = 1'b1;
                n_state        = ST_ROUND;
            end
            ST_ROUND: begin
                w_ctrl.en_round = 1'b1;
                n_state         = ST_SCALE;
            end
            ST_SCALE: begin
                w_ctrl.en_scale = 1'b1;
                n_state         = ST_COMMIT;
            end
            ST_COMMIT: begin
                w_ctrl.en_commit = 1'b1;
                n_state          = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_out_load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State register, phase and resample flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= '0;
            r_upd   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_in_xfer) begin
                r_upd   <= w_take;
                r_phase <= w_cfg.phase_step[PHASE_W-1] ? 32'd0 : w_phase_sum[31:0];
            end
        end
    end

    // Input capture; held stable while the lanes work on it.
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_in <= i_in_data;
        end
    end

    // Output register merges the two lanes into one transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_data.held_left  <= w_held_l;
            r_out_data.held_right <= w_held_r;
            r_out_data.updated    <= r_upd;
        end
    end

endmodule

// ===== hdl/sbd_check.sv =====
// ============================================================================
// sbd_check: port-level checks of the stereo bitcrusher
// Watches the top-level channels and flags handshake slips, a missing
// input stall and held samples that move without a resample.
// ============================================================================
module sbd_check (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input sbd_pkg::t_out_item o_out_data
);
    import sbd_pkg::*;

    logic                       w_in_xfer;
    logic                       w_out_xfer;
    logic                       r_seen;
    logic signed [SAMPLE_W-1:0] r_last_l;
    logic signed [SAMPLE_W-1:0] r_last_r;

    assign w_in_xfer  = i_in_valid & ~o_in_stall;
    assign w_out_xfer = o_out_valid & ~i_out_stall;

    // Last delivered held pair.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (w_out_xfer) begin
            r_seen <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_xfer) begin
            r_last_l <= o_out_data.held_left;
            r_last_r <= o_out_data.held_right;
        end
    end

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output valid dropped while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("output payload changed while stalled");

    // The block works on one pair at a time.
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> o_in_stall)
        else $error("input not stalled after a transfer");

    // Without a resample the held pair repeats the previous result.
    a_hold_repeat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_xfer && r_seen && !o_out_data.updated |->
            (o_out_data.held_left == r_last_l) && (o_out_data.held_right == r_last_r))
        else $error("held samples changed without a resample");

endmodule

bind stereo_bitcrusher_dither sbd_check u_sbd_check (.*);

// ===== tb/sv/testbench.sv =====
// ============================================================================
// testbench: self-checking bench for stereo_bitcrusher_dither
// Drives stereo pairs with random words through the valid/stall input channel
// and predicts every output transfer from an internal model of the hold-rate
// phase, the dither and error feedback, and the requantizer. Configuration
// goes through the APB port between phases, with readback. Both sides idle
// and stall at random.
// ============================================================================
module testbench;
    import sbd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_WAIT    = 18;
    localparam int SHOWN_ERRS  = 10;

    // Clock, reset and the ports of the block.
    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    t_in_item              in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             out_data;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [APB_ADDR_W-1:0] paddr     = '0;
    logic [APB_DATA_W-1:0] pwdata    = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Model copy of the configuration registers.
    logic [PHASE_W-1:0] cfg_phase_step  = PHASE_STEP_RST;
    logic [QSTEP_W-1:0] cfg_quant_step  = QUANT_STEP_RST;
    logic [RECIP_W-1:0] cfg_quant_recip = QUANT_RECIP_RST;
    logic [MODE_W-1:0]  cfg_dither_mode = DITHER_MODE_RST;

    // Model copy of the state: phase, held samples, newest and previous error.
    logic [31:0] hold_phase = '0;
    longint      held_val[2] = '{0, 0};
    longint      err_new[2]  = '{0, 0};
    longint      err_old[2]  = '{0, 0};

    // Predicted output transfers, oldest first.
    t_out_item held_q[$];

    // Bookkeeping.
    int  cycle_cnt   = 0;
    int  fail_cnt    = 0;
    int  n_sent      = 0;
    int  n_results   = 0;
    int  n_resampled = 0;
    int  n_writes    = 0;
    int  n_settings  = 0;
    int  stall_cnt   = 0;
    bit  send_burst  = 1'b0;
    bit  recv_burst  = 1'b0;
    t_out_item want;

    stereo_bitcrusher_dither dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #4 i_clk = ~i_clk;

    // Cycle counter with a hard stop.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results pending.",
                     cycle_cnt, held_q.size());
            $display("testbench: errors");
            $finish;
        end
    end

    // Counts a failure and reports the first few.
    function automatic void note_error(string msg);
        fail_cnt++;
        if (fail_cnt <= SHOWN_ERRS) $display("ERROR @%0d: %s", cycle_cnt, msg);
    endfunction

    // Clamps a value to a signed range of the given width.
    function automatic longint clamp(longint v, int w);
        longint hi;
        hi = (longint'(1) <<< (w - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    // Rounds a 16-fraction-bit value to a multiple of the step, using the
    // reciprocal as programmed; ties go away from zero.
    function automatic longint requant(longint xd);
        logic [63:0] mag;
        logic [95:0] prod;
        longint      n;
        longint      q;
        q    = longint'(cfg_quant_step);
        mag  = (xd < 0) ? 64'(-xd) : 64'(xd);
        prod = 96'(mag) * 96'(cfg_quant_recip);
        n    = longint'(((prod >> 32) + 96'h8000) >> 16);
        return (xd < 0) ? -(n * q) : n * q;
    endfunction

    // One lane: dither plus error feedback, requantize, update history.
    function automatic void crush_lane(int ch, longint x, longint ra, longint rb);
        longint q, e0, e1, dith, fb, xd, y;
        q    = longint'(cfg_quant_step);
        e0   = err_new[ch];
        e1   = err_old[ch];
        dith = 0;
        fb   = 0;
        case (cfg_dither_mode)
            DM_RECT: begin
                dith = (ra - 32768) * q;
            end
            DM_TRI, DM_TRI_ALT: begin
                dith = (ra - rb) * q;
            end
            DM_TRI_FO: begin
                dith = (ra - rb) * q;
                fb   = e0 * 32768;
            end
            DM_TRI_SO: begin
                dith = (ra - rb) * q;
                fb   = e0 * 65536 - e1 * 32768;
            end
            default: begin
                dith = 0;
            end
        endcase
        xd = x * 65536 + dith + fb;
        y  = requant(xd);
        err_old[ch]  = e0;
        err_new[ch]  = clamp(y - x, ERR_W);
        held_val[ch] = clamp(y, SAMPLE_W);
    endfunction

    // Advances the hold phase and works out the output of one tick.
    function automatic t_out_item predict_tick(t_in_item it);
        t_out_item   r;
        logic [32:0] sum;
        logic        take;
        if (cfg_phase_step[PHASE_W-1]) begin
            take       = 1'b1;
            hold_phase = '0;
        end else begin
            sum        = {1'b0, hold_phase} + {1'b0, cfg_phase_step[31:0]};
            take       = sum[32];
            hold_phase = sum[31:0];
        end
        if (take) begin
            crush_lane(0, longint'(it.sample_left),
                       longint'(it.rand_left_a), longint'(it.rand_left_b));
            crush_lane(1, longint'(it.sample_right),
                       longint'(it.rand_right_a), longint'(it.rand_right_b));
        end
        r.held_left  = SAMPLE_W'(held_val[0]);
        r.held_right = SAMPLE_W'(held_val[1]);
        r.updated    = take;
        return r;
    endfunction

    // Register write followed by a readback; updates the model copy.
    task automatic cfg_write(input logic [REG_IDX_W-1:0] idx,
                             input logic [APB_DATA_W-1:0] val);
        logic [APB_DATA_W-1:0] mask;
        logic [APB_DATA_W-1:0] got;
        case (idx)
            REG_PHASE_STEP:  mask = (64'd1 << PHASE_W) - 1;
            REG_QUANT_STEP:  mask = (64'd1 << QSTEP_W) - 1;
            REG_QUANT_RECIP: mask = (64'd1 << RECIP_W) - 1;
            default:         mask = (64'd1 << MODE_W) - 1;
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(idx) << 3;
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_PHASE_STEP:  cfg_phase_step  = val[PHASE_W-1:0];
            REG_QUANT_STEP:  cfg_quant_step  = val[QSTEP_W-1:0];
            REG_QUANT_RECIP: cfg_quant_recip = val[RECIP_W-1:0];
            default:         cfg_dither_mode = val[MODE_W-1:0];
        endcase
        n_writes++;
        // Read the register back.
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        got = prdata;
        if ((got & mask) !== (val & mask))
            note_error($sformatf("register %0d readback: expected %h, got %h",
                                 idx, val & mask, got & mask));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Writes all four registers as one setting.
    task automatic apply_setting(input logic [APB_DATA_W-1:0] phase,
                                 input logic [APB_DATA_W-1:0] qstep,
                                 input logic [APB_DATA_W-1:0] recip,
                                 input logic [APB_DATA_W-1:0] mode);
        cfg_write(REG_PHASE_STEP, phase);
        cfg_write(REG_QUANT_STEP, qstep);
        cfg_write(REG_QUANT_RECIP, recip);
        cfg_write(REG_DITHER_MODE, mode);
        n_settings++;
    endtask

    // Stops sending and waits until every predicted result has been checked.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (held_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Sends one pair after a random gap and records its predicted result.
    task automatic send_pair(input t_in_item it);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, MAX_WAIT);
        if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        held_q.push_back(predict_tick(it));
        n_sent++;
    endtask

    function automatic t_in_item make_pair(logic signed [SAMPLE_W-1:0] l,
                                           logic signed [SAMPLE_W-1:0] r,
                                           logic [RAND_W-1:0] la, logic [RAND_W-1:0] lb,
                                           logic [RAND_W-1:0] ra, logic [RAND_W-1:0] rb);
        t_in_item it;
        it.sample_left  = l;
        it.sample_right = r;
        it.rand_left_a  = la;
        it.rand_left_b  = lb;
        it.rand_right_a = ra;
        it.rand_right_b = rb;
        return it;
    endfunction

    // Audio sample biased toward full scale, silence and small signals.
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return {1'b0, {(SAMPLE_W-1){1'b1}}};
            1:       return {1'b1, {(SAMPLE_W-1){1'b0}}};
            2:       return SAMPLE_W'(int'($urandom_range(0, 64)) - 32);
            3, 4:    return SAMPLE_W'($signed(20'($urandom)));
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic t_in_item rand_pair();
        return make_pair(pick_sample(), pick_sample(),
                         RAND_W'($urandom), RAND_W'($urandom),
                         RAND_W'($urandom), RAND_W'($urandom));
    endfunction

    // Output side: checks each transfer and stalls at random.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_valid && !out_stall) begin
                n_results++;
                if (held_q.size() == 0) begin
                    note_error($sformatf("unexpected result L=%h R=%h upd=%b",
                               out_data.held_left, out_data.held_right,
                               out_data.updated));
                end else begin
                    want = held_q.pop_front();
                    if (want.updated) n_resampled++;
                    if (out_data.held_left !== want.held_left ||
                        out_data.held_right !== want.held_right ||
                        out_data.updated !== want.updated)
                        note_error($sformatf(
                            "result %0d: expected L=%h R=%h upd=%b, got L=%h R=%h upd=%b",
                            n_results, want.held_left, want.held_right, want.updated,
                            out_data.held_left, out_data.held_right,
                            out_data.updated));
                end
                if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
                stall_cnt = recv_burst ? 0 : $urandom_range(0, MAX_WAIT);
                if (stall_cnt != 0) out_stall <= 1'b1;
            end else if (out_stall) begin
                stall_cnt--;
                if (stall_cnt <= 0) out_stall <= 1'b0;
            end
        end
    end

    // Reset values: forced resample every tick, triangular dither.
    task automatic test_reset_defaults();
        send_pair(make_pair({1'b0, {(SAMPLE_W-1){1'b1}}}, {1'b1, {(SAMPLE_W-1){1'b0}}},
                            16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF));
        send_pair(make_pair('0, '0, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF));
        send_pair(make_pair({1'b1, {(SAMPLE_W-1){1'b0}}}, {1'b0, {(SAMPLE_W-1){1'b1}}},
                            16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000));
    endtask

    // Every dither code, the two unused ones included, with feedback history.
    task automatic test_dither_modes();
        for (int m = 0; m < 8; m++) begin
            wait_idle();
            cfg_write(REG_DITHER_MODE, APB_DATA_W'(m));
            n_settings++;
            send_pair(make_pair(24'sd1234567, -24'sd7654321,
                                16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF));
            send_pair(rand_pair());
        end
    endtask

    // Phase carry: half rate gives hold, resample, hold.
    task automatic test_hold_rate();
        wait_idle();
        apply_setting(64'h8000_0000, 64'd20480, 64'd209715, 64'(DM_TRI_SO));
        repeat (3) send_pair(rand_pair());
    endtask

    // Zero step, zero reciprocal, and an inconsistent reciprocal that saturates.
    task automatic test_step_corners();
        wait_idle();
        apply_setting(64'h1_FFFF_FFFF, 64'd0, 64'd209715, 64'(DM_TRI_FO));
        send_pair(rand_pair());
        wait_idle();
        cfg_write(REG_QUANT_STEP, 64'd4096);
        cfg_write(REG_QUANT_RECIP, 64'd0);
        send_pair(rand_pair());
        wait_idle();
        cfg_write(REG_QUANT_STEP, 64'd2621440);
        cfg_write(REG_QUANT_RECIP, 64'hFFFF_FFFF);
        send_pair(make_pair({1'b0, {(SAMPLE_W-1){1'b1}}}, {1'b1, {(SAMPLE_W-1){1'b0}}},
                            16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF));
        n_settings++;
    endtask

    // Random settings, each followed by a run of random pairs.
    task automatic test_random_phases();
        logic [APB_DATA_W-1:0] phase, qstep, recip;
        for (int p = 0; p < 10; p++) begin
            case ($urandom_range(0, 7))
                0, 1:    phase = 64'h1_0000_0000;
                2:       phase = 64'h1_FFFF_FFFF;
                3:       phase = 64'($urandom);
                4:       phase = 64'h8000_0000 >> $urandom_range(0, 3);
                5:       phase = 64'hFFFF_FFFF;
                6:       phase = 64'h0;
                default: phase = 64'($urandom_range(32'h4000_0000, 32'hF000_0000));
            endcase
            case ($urandom_range(0, 9))
                0:       qstep = 64'd1;
                1:       qstep = 64'd2621440;
                2:       qstep = 64'($urandom_range(1, 2621440));
                default: qstep = 64'd5242880 >> $urandom_range(1, 22);
            endcase
            recip = 64'h1_0000_0000 / qstep;
            if (recip > 64'hFFFF_FFFF) recip = 64'hFFFF_FFFF;
            if ($urandom_range(0, 7) == 0) recip = 64'($urandom);
            wait_idle();
            apply_setting(phase, qstep, recip, 64'($urandom_range(0, 7)));
            repeat (115) send_pair(rand_pair());
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_dither_modes();
        test_hold_rate();
        test_step_corners();
        test_random_phases();

        // Drain and let the pipeline settle.
        wait_idle();
        repeat (16) @(posedge i_clk);

        $display("Run covered %0d stereo pairs (%0d resampled) and %0d results checked,",
                 n_sent, n_resampled, n_results);
        $display("over %0d register settings with %0d writes; %0d failures.",
                 n_settings, n_writes, fail_cnt);
        if (fail_cnt == 0 && held_q.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/sbd_pkg.sv
hdl/sbd_regs.sv
hdl/sbd_lane.sv
hdl/stereo_bitcrusher_dither.sv
hdl/sbd_check.sv
tb/sv/testbench.sv
